FILE: sv/cdbc_pkg.sv
package cdbc_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int LINE_BITS_DEF   = 16;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 3;
    localparam int OUT_LINE_W      = 16;

    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_DQUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_PAREN    = 3'd1,
        KIND_BRACKET  = 3'd2,
        KIND_BRACE    = 3'd3,
        KIND_SQUOTE   = 3'd4,
        KIND_DQUOTE   = 3'd5,
        KIND_COMMENT  = 3'd6,
        KIND_OVERFLOW = 3'd7
    } kind_t;

    // where the line number of a report item comes from
    typedef enum logic [2:0] {
        SRC_ZERO    = 3'd0,
        SRC_MODE    = 3'd1,
        SRC_PAREN   = 3'd2,
        SRC_BRACKET = 3'd3,
        SRC_BRACE   = 3'd4
    } src_t;

    typedef struct packed {
        logic  step;
        logic  clear;
        logic  rd_start;
        logic  rd_advance;
        src_t  rd_src;
        logic  load_out;
        kind_t out_kind;
        src_t  out_src;
        logic  out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic mode_block;
        logic mode_quote;
        logic quote_double;
        logic overflowed;
        logic paren_any;
        logic bracket_any;
        logic brace_any;
        logic paren_more;
        logic bracket_more;
        logic brace_more;
    } dp_status_t;

endpackage

FILE: sv/cdbc_stack.sv
module cdbc_stack
    import cdbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 pop,
    input  logic                 clear,
    input  logic                 rd_start,
    input  logic                 rd_advance,
    input  logic [LINE_BITS-1:0] push_line,
    output logic                 full,
    output logic                 nonempty,
    output logic                 more,
    output logic [LINE_BITS-1:0] rd_line
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [LINE_BITS-1:0] mem [STACK_DEPTH];
    logic [LINE_BITS-1:0] rd_line_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [DEPTH_W-1:0]   idx_reg;
    logic [DEPTH_W-1:0]   idx_next;
    logic [DEPTH_W-1:0]   idx_inc;
    logic [IDX_W-1:0]     rd_addr;
    logic                 do_push;

    assign full     = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign nonempty = (depth_reg != '0);
    assign idx_inc  = idx_reg + 1'b1;
    assign more     = (idx_inc < depth_reg);
    assign do_push  = push && !full;
    assign rd_addr  = rd_start ? '0 : idx_inc[IDX_W-1:0];
    assign rd_line  = rd_line_reg;

    always_comb
    begin
        depth_next = depth_reg;
        if (clear)
        begin
            depth_next = '0;
        end
        else if (do_push)
        begin
            depth_next = depth_reg + 1'b1;
        end
        else if (pop && nonempty)
        begin
            depth_next = depth_reg - 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (rd_start)
        begin
            idx_next = '0;
        end
        else if (rd_advance)
        begin
            idx_next = idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            idx_reg   <= idx_next;
        end
    end

    // one write port at the top of stack, one registered read port for the report walk
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[depth_reg[IDX_W-1:0]] <= push_line;
        end
        if (rd_start || rd_advance)
        begin
            rd_line_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/cdbc_datapath.sv
module cdbc_datapath
    import cdbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [BYTE_W-1:0]     text_byte,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [KIND_W-1:0]     item_kind,
    output logic [OUT_LINE_W-1:0] open_line,
    output logic                  last_result
);

    typedef enum logic [1:0] {
        MODE_CODE  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2,
        MODE_QUOTE = 2'd3
    } mode_t;

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic                  quote_dbl_reg;
    logic                  quote_dbl_next;
    logic                  held_slash_reg;
    logic                  held_slash_next;
    logic                  held_star_reg;
    logic                  held_star_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [LINE_BITS-1:0]  line_reg;
    logic [LINE_BITS-1:0]  line_next;
    logic [LINE_BITS-1:0]  mode_line_reg;
    logic [LINE_BITS-1:0]  mode_line_next;

    kind_t                 kind_reg;
    logic [OUT_LINE_W-1:0] open_line_reg;
    logic                  last_reg;
    logic [LINE_BITS-1:0]  sel_line;

    logic                  code_ok;
    logic                  paren_push;
    logic                  paren_pop;
    logic                  bracket_push;
    logic                  bracket_pop;
    logic                  brace_push;
    logic                  brace_pop;
    logic                  paren_full;
    logic                  bracket_full;
    logic                  brace_full;
    logic                  paren_any;
    logic                  bracket_any;
    logic                  brace_any;
    logic                  paren_more;
    logic                  bracket_more;
    logic                  brace_more;
    logic [LINE_BITS-1:0]  paren_rd;
    logic [LINE_BITS-1:0]  bracket_rd;
    logic [LINE_BITS-1:0]  brace_rd;

    always_comb
    begin
        mode_next       = mode_reg;
        quote_dbl_next  = quote_dbl_reg;
        held_slash_next = held_slash_reg;
        held_star_next  = held_star_reg;
        ovf_next        = ovf_reg;
        line_next       = line_reg;
        mode_line_next  = mode_line_reg;
        code_ok         = 1'b0;
        paren_push      = 1'b0;
        paren_pop       = 1'b0;
        bracket_push    = 1'b0;
        bracket_pop     = 1'b0;
        brace_push      = 1'b0;
        brace_pop       = 1'b0;
        if (cmd.clear)
        begin
            mode_next       = MODE_CODE;
            quote_dbl_next  = 1'b0;
            held_slash_next = 1'b0;
            held_star_next  = 1'b0;
            ovf_next        = 1'b0;
            line_next       = LINE_BITS'(1);
            mode_line_next  = '0;
        end
        else if (cmd.step)
        begin
            unique case (mode_reg)
                MODE_CODE:
                begin
                    code_ok = 1'b1;
                    if (held_slash_reg)
                    begin
                        held_slash_next = 1'b0;
                        if (text_byte == CH_SLASH)
                        begin
                            mode_next      = MODE_LINE;
                            mode_line_next = line_reg;
                            code_ok        = 1'b0;
                        end
                        else if (text_byte == CH_STAR)
                        begin
                            mode_next      = MODE_BLOCK;
                            held_star_next = 1'b0;
                            mode_line_next = line_reg;
                            code_ok        = 1'b0;
                        end
                    end
                    if (code_ok)
                    begin
                        case (text_byte) inside
                            CH_SLASH:
                            begin
                                held_slash_next = 1'b1;
                            end
                            CH_DQUOTE, CH_SQUOTE:
                            begin
                                mode_next      = MODE_QUOTE;
                                quote_dbl_next = (text_byte == CH_DQUOTE);
                                mode_line_next = line_reg;
                            end
                            CH_LPAREN:  paren_push   = 1'b1;
                            CH_RPAREN:  paren_pop    = 1'b1;
                            CH_LBRACK:  bracket_push = 1'b1;
                            CH_RBRACK:  bracket_pop  = 1'b1;
                            CH_LBRACE:  brace_push   = 1'b1;
                            CH_RBRACE:  brace_pop    = 1'b1;
                            default:    ;
                        endcase
                    end
                end
                MODE_LINE:
                begin
                    if (text_byte == CH_NEWLINE)
                    begin
                        mode_next = MODE_CODE;
                    end
                end
                MODE_BLOCK:
                begin
                    // a star seen inside the comment is needed before the closing slash
                    if (held_star_reg && text_byte == CH_SLASH)
                    begin
                        mode_next      = MODE_CODE;
                        held_star_next = 1'b0;
                    end
                    else
                    begin
                        held_star_next = (text_byte == CH_STAR);
                    end
                end
                MODE_QUOTE:
                begin
                    if (text_byte == (quote_dbl_reg ? CH_DQUOTE : CH_SQUOTE))
                    begin
                        mode_next = MODE_CODE;
                    end
                end
            endcase
            if ((paren_push && paren_full) || (bracket_push && bracket_full)
                || (brace_push && brace_full))
            begin
                ovf_next = 1'b1;
            end
            // line count saturates
            if (text_byte == CH_NEWLINE && line_reg != '1)
            begin
                line_next = line_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_CODE;
            quote_dbl_reg  <= 1'b0;
            held_slash_reg <= 1'b0;
            held_star_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            line_reg       <= LINE_BITS'(1);
            mode_line_reg  <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            quote_dbl_reg  <= quote_dbl_next;
            held_slash_reg <= held_slash_next;
            held_star_reg  <= held_star_next;
            ovf_reg        <= ovf_next;
            line_reg       <= line_next;
            mode_line_reg  <= mode_line_next;
        end
    end

    cdbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_paren (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (paren_push),
        .pop        (paren_pop),
        .clear      (cmd.clear),
        .rd_start   (cmd.rd_start && cmd.rd_src == SRC_PAREN),
        .rd_advance (cmd.rd_advance && cmd.rd_src == SRC_PAREN),
        .push_line  (line_reg),
        .full       (paren_full),
        .nonempty   (paren_any),
        .more       (paren_more),
        .rd_line    (paren_rd)
    );

    cdbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_bracket (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (bracket_push),
        .pop        (bracket_pop),
        .clear      (cmd.clear),
        .rd_start   (cmd.rd_start && cmd.rd_src == SRC_BRACKET),
        .rd_advance (cmd.rd_advance && cmd.rd_src == SRC_BRACKET),
        .push_line  (line_reg),
        .full       (bracket_full),
        .nonempty   (bracket_any),
        .more       (bracket_more),
        .rd_line    (bracket_rd)
    );

    cdbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_brace (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (brace_push),
        .pop        (brace_pop),
        .clear      (cmd.clear),
        .rd_start   (cmd.rd_start && cmd.rd_src == SRC_BRACE),
        .rd_advance (cmd.rd_advance && cmd.rd_src == SRC_BRACE),
        .push_line  (line_reg),
        .full       (brace_full),
        .nonempty   (brace_any),
        .more       (brace_more),
        .rd_line    (brace_rd)
    );

    always_comb
    begin
        status.mode_block   = (mode_reg == MODE_BLOCK);
        status.mode_quote   = (mode_reg == MODE_QUOTE);
        status.quote_double = quote_dbl_reg;
        status.overflowed   = ovf_reg;
        status.paren_any    = paren_any;
        status.bracket_any  = bracket_any;
        status.brace_any    = brace_any;
        status.paren_more   = paren_more;
        status.bracket_more = bracket_more;
        status.brace_more   = brace_more;
    end

    always_comb
    begin
        case (cmd.out_src)
            SRC_MODE:    sel_line = mode_line_reg;
            SRC_PAREN:   sel_line = paren_rd;
            SRC_BRACKET: sel_line = bracket_rd;
            SRC_BRACE:   sel_line = brace_rd;
            default:     sel_line = '0;
        endcase
    end

    // output register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            kind_reg      <= cmd.out_kind;
            open_line_reg <= OUT_LINE_W'(sel_line);
            last_reg      <= cmd.out_last;
        end
    end

    assign item_kind   = kind_reg;
    assign open_line   = open_line_reg;
    assign last_result = last_reg;

endmodule

FILE: sv/cdbc_ctrl.sv
module cdbc_ctrl
    import cdbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       end_of_text,
    input  logic       out_ready,
    input  dp_status_t status,
    output logic       in_ready,
    output logic       out_valid,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_SCAN = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef enum logic [2:0] {
        PH_MODE    = 3'd0,
        PH_PAREN   = 3'd1,
        PH_BRACKET = 3'd2,
        PH_BRACE   = 3'd3,
        PH_OVF     = 3'd4,
        PH_NONE    = 3'd5
    } ph_t;

    state_t     state_reg;
    state_t     state_next;
    ph_t        ph_reg;
    ph_t        ph_next;
    ph_t        ph_after;
    logic       first_reg;
    logic       first_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [4:0] has;
    logic       is_stack;
    logic       ph_more;
    logic       slot_free;
    src_t       ph_src;
    kind_t      ph_kind;
    kind_t      mode_kind;

    // first phase at or after from that has something to report
    function automatic ph_t pick_phase(input logic [2:0] from, input logic [4:0] avail);
        ph_t p;
        p = PH_NONE;
        for (int i = 4; i >= 0; i--)
        begin
            if (avail[i] && 3'(i) >= from)
            begin
                p = ph_t'(3'(i));
            end
        end
        return p;
    endfunction

    assign has = {status.overflowed, status.brace_any, status.bracket_any,
                  status.paren_any, status.mode_block || status.mode_quote};

    assign mode_kind = status.mode_block ? KIND_COMMENT
                     : (status.quote_double ? KIND_DQUOTE : KIND_SQUOTE);

    always_comb
    begin
        unique case (ph_reg)
            PH_MODE:
            begin
                ph_src = SRC_MODE; ph_kind = mode_kind; is_stack = 1'b0; ph_more = 1'b0;
            end
            PH_PAREN:
            begin
                ph_src = SRC_PAREN; ph_kind = KIND_PAREN; is_stack = 1'b1;
                ph_more = status.paren_more;
            end
            PH_BRACKET:
            begin
                ph_src = SRC_BRACKET; ph_kind = KIND_BRACKET; is_stack = 1'b1;
                ph_more = status.bracket_more;
            end
            PH_BRACE:
            begin
                ph_src = SRC_BRACE; ph_kind = KIND_BRACE; is_stack = 1'b1;
                ph_more = status.brace_more;
            end
            PH_OVF:
            begin
                ph_src = SRC_ZERO; ph_kind = KIND_OVERFLOW; is_stack = 1'b0; ph_more = 1'b0;
            end
            PH_NONE:
            begin
                ph_src = SRC_ZERO; ph_kind = KIND_NONE; is_stack = 1'b0; ph_more = 1'b0;
            end
            default:
            begin
                ph_src = SRC_ZERO; ph_kind = KIND_NONE; is_stack = 1'b0; ph_more = 1'b0;
            end
        endcase
    end

    assign ph_after  = pick_phase(ph_reg + 3'd1, has);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_SCAN);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        first_next = first_reg;
        cmd        = '0;
        cmd.step   = in_valid && in_ready && !end_of_text;
        unique case (state_reg)
            ST_SCAN:
            begin
                if (in_valid && end_of_text)
                begin
                    ph_next    = pick_phase(3'd0, has);
                    first_next = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (is_stack)
                begin
                    cmd.rd_src     = ph_src;
                    cmd.rd_start   = first_reg;
                    cmd.rd_advance = !first_reg;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = ph_kind;
                    cmd.out_src  = ph_src;
                    if (is_stack && ph_more)
                    begin
                        first_next = 1'b0;
                        state_next = ST_READ;
                    end
                    else if (ph_after == PH_NONE)
                    begin
                        cmd.out_last = 1'b1;
                        cmd.clear    = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        ph_next    = ph_after;
                        first_next = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SCAN;
            ph_reg        <= PH_NONE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/c_delimiter_balance_checker_unit.sv
// delimiter balance checker for c source text
// input channel (in_valid/in_ready) carries one text_byte per transfer; a
// transfer with end_of_text set ends the text and its byte is ignored
// output channel (out_valid/out_ready) carries the end-of-text report only:
// open block comment or quote first, then parentheses, brackets and braces
// oldest first, then one overflow item; a lone item_kind 0 when nothing is open;
// last_result marks the final item of the report
// ordinary bytes are taken back to back and give no result, in_ready stays high
// after an end_of_text transfer in_ready drops; each report item passes through a
// read state, which for a stack item does the registered read of a stack memory,
// and an emit state that loads the output register
// a stalled output register holds the report walk; once the last item is
// loaded all scan state is cleared and in_ready rises while it waits
// reset clears the scan mode, line counter (back to 1), stack depths and the
// overflow mark; stack contents are not cleared and need no clearing pass
module c_delimiter_balance_checker_unit
    import cdbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  end_of_text,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     item_kind,
    output logic [OUT_LINE_W-1:0] open_line,
    output logic                  last_result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cdbc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .end_of_text (end_of_text),
        .out_ready   (out_ready),
        .status      (status),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .cmd         (cmd)
    );

    cdbc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .cmd         (cmd),
        .status      (status),
        .item_kind   (item_kind),
        .open_line   (open_line),
        .last_result (last_result)
    );

    // end of text stops the input until the report is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_text |=> !in_ready)
        else $error("input still ready after end of text");

    // a report item that is not the last keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
        else $error("input reopened in the middle of a report");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == KIND_NONE || item_kind == KIND_OVERFLOW)
        |-> open_line == '0)
        else $error("line number on an item that carries none");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_NONE |-> last_result)
        else $error("empty report item not marked last");

endmodule

FILE: test/c_delimiter_balance_checker_unit_test.sv
module c_delimiter_balance_checker_unit_test;
    import cdbc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 150;
    localparam int DRAIN_CYCLES  = 80;
    localparam logic [BYTE_W-1:0] LETTER_LO = 8'h61;
    localparam logic [BYTE_W-1:0] LETTER_HI = 8'h7A;
    localparam logic [LINE_BITS_DEF-1:0] LINE_TOP = {LINE_BITS_DEF{1'b1}};

    typedef enum logic [1:0] {
        SCAN_CODE,
        SCAN_LINE_CMT,
        SCAN_BLOCK_CMT,
        SCAN_QUOTE
    } scan_mode_t;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              eot;
    } text_item_t;

    typedef struct {
        kind_t                 kind;
        logic [OUT_LINE_W-1:0] line;
        logic                  last;
    } report_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     text_byte = '0;
    logic                  end_of_text = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_W-1:0]     item_kind;
    logic [OUT_LINE_W-1:0] open_line;
    logic                  last_result;

    text_item_t   text_fifo[$];
    report_item_t due_reports[$];
    text_item_t   next_item;
    report_item_t want;

    bit in_taken = 1'b0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int reports_checked = 0;
    int reports_predicted = 0;
    int bytes_queued = 0;
    int texts_queued = 0;

    // predictor state
    scan_mode_t               scan_mode;
    logic                     quote_dq;
    logic                     slash_held;
    logic                     star_held;
    logic [LINE_BITS_DEF-1:0] line_no;
    logic [LINE_BITS_DEF-1:0] mode_line;
    logic [LINE_BITS_DEF-1:0] stack_ln[3][STACK_DEPTH_DEF];
    int                       stack_depth[3];
    logic                     overflow_seen;

    c_delimiter_balance_checker_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_kind   (item_kind),
        .open_line   (open_line),
        .last_result (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < 50)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic clear_scan();
        scan_mode = SCAN_CODE;
        quote_dq = 1'b0;
        slash_held = 1'b0;
        star_held = 1'b0;
        line_no = 1;
        mode_line = '0;
        for (int s = 0; s < 3; s++)
            stack_depth[s] = 0;
        overflow_seen = 1'b0;
    endtask

    task automatic open_delim(input kind_t k);
        int s;
        s = int'(k) - int'(KIND_PAREN);
        if (stack_depth[s] < STACK_DEPTH_DEF)
        begin
            stack_ln[s][stack_depth[s]] = line_no;
            stack_depth[s]++;
        end
        else
            overflow_seen = 1'b1;
    endtask

    task automatic close_delim(input kind_t k);
        int s;
        s = int'(k) - int'(KIND_PAREN);
        if (stack_depth[s] > 0)
            stack_depth[s]--;
    endtask

    function automatic report_item_t mk_item(input kind_t k, input logic [LINE_BITS_DEF-1:0] ln);
        report_item_t r;
        r.kind = k;
        r.line = ln[OUT_LINE_W-1:0];
        r.last = 1'b0;
        return r;
    endfunction

    task automatic queue_report();
        report_item_t batch[$];
        report_item_t r;
        if (scan_mode == SCAN_BLOCK_CMT)
            batch.push_back(mk_item(KIND_COMMENT, mode_line));
        else if (scan_mode == SCAN_QUOTE)
            batch.push_back(mk_item(quote_dq ? KIND_DQUOTE : KIND_SQUOTE, mode_line));
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < stack_depth[s]; i++)
                batch.push_back(mk_item(kind_t'(int'(KIND_PAREN) + s), stack_ln[s][i]));
        if (overflow_seen)
            batch.push_back(mk_item(KIND_OVERFLOW, '0));
        if (batch.size() == 0)
            batch.push_back(mk_item(KIND_NONE, '0));
        for (int i = 0; i < batch.size(); i++)
        begin
            r = batch[i];
            r.last = (i == batch.size() - 1);
            due_reports.push_back(r);
            reports_predicted++;
        end
        clear_scan();
    endtask

    task automatic code_char(input logic [BYTE_W-1:0] ch);
        case (ch)
            CH_SLASH:  slash_held = 1'b1;
            CH_DQUOTE, CH_SQUOTE:
            begin
                scan_mode = SCAN_QUOTE;
                quote_dq = (ch == CH_DQUOTE);
                mode_line = line_no;
            end
            CH_LPAREN: open_delim(KIND_PAREN);
            CH_RPAREN: close_delim(KIND_PAREN);
            CH_LBRACK: open_delim(KIND_BRACKET);
            CH_RBRACK: close_delim(KIND_BRACKET);
            CH_LBRACE: open_delim(KIND_BRACE);
            CH_RBRACE: close_delim(KIND_BRACE);
            default: ;
        endcase
    endtask

    task automatic scan_char(input logic [BYTE_W-1:0] ch, input logic eot);
        bit taken_by_slash;
        taken_by_slash = 1'b0;
        if (eot)
            queue_report();
        else
        begin
            case (scan_mode)
                SCAN_CODE:
                begin
                    // a held slash either opens a comment or is dropped
                    if (slash_held)
                    begin
                        slash_held = 1'b0;
                        if (ch == CH_SLASH)
                        begin
                            scan_mode = SCAN_LINE_CMT;
                            mode_line = line_no;
                            taken_by_slash = 1'b1;
                        end
                        else if (ch == CH_STAR)
                        begin
                            scan_mode = SCAN_BLOCK_CMT;
                            star_held = 1'b0;
                            mode_line = line_no;
                            taken_by_slash = 1'b1;
                        end
                    end
                    if (!taken_by_slash)
                        code_char(ch);
                end
                SCAN_LINE_CMT:
                    if (ch == CH_NEWLINE)
                        scan_mode = SCAN_CODE;
                SCAN_BLOCK_CMT:
                    if (star_held && ch == CH_SLASH)
                    begin
                        scan_mode = SCAN_CODE;
                        star_held = 1'b0;
                    end
                    else
                        star_held = (ch == CH_STAR);
                default:
                    if (ch == (quote_dq ? CH_DQUOTE : CH_SQUOTE))
                        scan_mode = SCAN_CODE;
            endcase
            if (ch == CH_NEWLINE && line_no != LINE_TOP)
                line_no = line_no + 1'b1;
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (text_fifo.size() != 0 && (calm || $urandom_range(99) >= 31))
            begin
                next_item = text_fifo.pop_front();
                in_valid <= 1'b1;
                text_byte <= next_item.ch;
                end_of_text <= next_item.eot;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 31);
    end

    // both transfers are sampled here; results are checked before the
    // input of the same edge is predicted
    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_reports.size() == 0)
                flag_mismatch($sformatf("unexpected report item kind %0d line %0d last %0d",
                                        item_kind, open_line, last_result));
            else
            begin
                want = due_reports.pop_front();
                reports_checked++;
                if (item_kind !== want.kind)
                    flag_mismatch($sformatf("item_kind %0d, expected %0d", item_kind, want.kind));
                if (open_line !== want.line)
                    flag_mismatch($sformatf("open_line %0d, expected %0d (kind %0d)",
                                            open_line, want.line, want.kind));
                if (last_result !== want.last)
                    flag_mismatch($sformatf("last_result %0d, expected %0d (kind %0d)",
                                            last_result, want.last, want.kind));
            end
        end
        if (rst_n && in_taken)
            scan_char(text_byte, end_of_text);
    end

    task automatic put(input logic [BYTE_W-1:0] ch);
        text_item_t t;
        t.ch = ch;
        t.eot = 1'b0;
        text_fifo.push_back(t);
        bytes_queued++;
    endtask

    task automatic end_text();
        text_item_t t;
        t.ch = 8'($urandom_range(255));
        t.eot = 1'b1;
        text_fifo.push_back(t);
        texts_queued++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (text_fifo.size() != 0 || in_valid || due_reports.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] letter();
        return 8'($urandom_range(LETTER_HI, LETTER_LO));
    endfunction

    function automatic logic [BYTE_W-1:0] opener();
        case ($urandom_range(2))
            0: return CH_LPAREN;
            1: return CH_LBRACK;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] closer();
        case ($urandom_range(2))
            0: return CH_RPAREN;
            1: return CH_RBRACK;
            default: return CH_RBRACE;
        endcase
    endfunction

    // body of a comment or literal; never the character that would end it
    function automatic logic [BYTE_W-1:0] inner_char(input logic [BYTE_W-1:0] stop);
        logic [BYTE_W-1:0] c;
        case ($urandom_range(7))
            0: c = CH_STAR;
            1: c = CH_SLASH;
            2: c = opener();
            3: c = closer();
            4: c = CH_NEWLINE;
            5: c = CH_SQUOTE;
            6: c = CH_DQUOTE;
            default: c = letter();
        endcase
        if (c == stop)
            c = letter();
        return c;
    endfunction

    task automatic add_token();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            put(opener());
        else if (roll < 35)
            put(closer());
        else if (roll < 47)
            put(CH_NEWLINE);
        else if (roll < 60)
            repeat ($urandom_range(4, 1)) put(letter());
        else if (roll < 66)
        begin
            put(CH_SLASH);
            put(CH_STAR);
            repeat ($urandom_range(4)) put(inner_char(CH_SLASH));
            put(CH_STAR);
            put(CH_SLASH);
        end
        else if (roll < 71)
        begin
            put(CH_SLASH);
            put(CH_SLASH);
            repeat ($urandom_range(4)) put(inner_char(CH_NEWLINE));
            put(CH_NEWLINE);
        end
        else if (roll < 77)
        begin
            put(CH_DQUOTE);
            repeat ($urandom_range(4)) put(inner_char(CH_DQUOTE));
            put(CH_DQUOTE);
        end
        else if (roll < 81)
        begin
            put(CH_SQUOTE);
            put(inner_char(CH_SQUOTE));
            put(CH_SQUOTE);
        end
        else if (roll < 86)
        begin
            put(CH_SLASH);
            put(letter());
        end
        else if (roll < 93)
            put(8'($urandom_range(255)));
        else
        begin
            // broken: an opener that is left hanging or a stray star
            case ($urandom_range(3))
                0: put(CH_DQUOTE);
                1: put(CH_SQUOTE);
                2:
                begin
                    put(CH_SLASH);
                    put(CH_STAR);
                end
                default: put(CH_STAR);
            endcase
        end
    endtask

    task automatic add_random_text();
        int tokens;
        tokens = ($urandom_range(9) == 0) ? $urandom_range(50, 30) : $urandom_range(14);
        repeat (tokens) add_token();
        end_text();
    endtask

    initial
    begin
        int first_random;
        int random_texts;
        clear_scan();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty text and unclosed delimiters on three lines
        end_text();
        put(CH_LPAREN); put(CH_NEWLINE); put(CH_LBRACK); put(CH_NEWLINE); put(CH_LBRACE);
        put(8'h00); put(8'hFF);
        end_text();
        // closers on empty stacks, and a closer that is not of its own kind
        put(CH_RPAREN); put(CH_RBRACK); put(CH_RBRACE); put(CH_LPAREN); put(CH_RBRACK);
        end_text();
        // line comment ended by newline, then one left open at the end
        put(CH_SLASH); put(CH_SLASH); put(CH_LPAREN); put(CH_NEWLINE); put(CH_LPAREN);
        put(CH_SLASH); put(CH_SLASH); put(CH_LBRACE);
        end_text();
        // slash-star-slash does not close a block comment
        put(CH_SLASH); put(CH_STAR); put(CH_SLASH); put(CH_LPAREN);
        end_text();
        put(CH_SLASH); put(CH_STAR); put(CH_LPAREN); put(CH_STAR); put(CH_STAR); put(CH_SLASH);
        put(CH_LPAREN);
        end_text();
        // dropped held slash, and a slash held at the end
        put(CH_SLASH); put(CH_LBRACK); put(CH_SLASH);
        end_text();
        // quotes close only on their own kind, newlines inside
        put(CH_DQUOTE); put(CH_SQUOTE); put(CH_NEWLINE); put(CH_LPAREN); put(CH_DQUOTE);
        put(CH_LPAREN);
        end_text();
        put(CH_SQUOTE); put(CH_DQUOTE);
        end_text();
        // longest report: all stacks full, overflow and an open quote
        repeat (STACK_DEPTH_DEF) put(CH_LPAREN);
        put(CH_NEWLINE);
        repeat (STACK_DEPTH_DEF) put(CH_LBRACK);
        put(CH_NEWLINE);
        repeat (STACK_DEPTH_DEF) put(CH_LBRACE);
        put(CH_LPAREN); put(CH_DQUOTE);
        end_text();
        wait_drained();

        // receiver holds off while the sender keeps offering text
        hold_request = 1'b1;
        repeat (STACK_DEPTH_DEF + 2) put(CH_LPAREN);
        put(CH_NEWLINE);
        repeat (5) put(CH_LBRACE);
        end_text();
        put(CH_LBRACK); put(CH_LBRACK);
        end_text();
        repeat (4) add_random_text();
        wait_drained();

        first_random = bytes_queued;
        random_texts = 0;
        while (bytes_queued - first_random < RANDOM_BYTES)
        begin
            calm = (random_texts >= 1 && random_texts < 4);
            add_random_text();
            random_texts++;
            while (text_fifo.size() > 40)
                @(posedge clk);
        end
        wait_drained();
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_reports.size() != 0)
            flag_mismatch($sformatf("%0d report items never arrived", due_reports.size()));
        $display("%0d texts, %0d text bytes, %0d report items checked", texts_queued,
                 bytes_queued, reports_checked);
        $display("incl. comments, quotes, empty-stack closers, overflow and long output stalls");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
